@@ sv/pafcp_pkg.sv @@
// Shared widths, register codes, stage types and axis geometry functions for the popup placer.
package pafcp_pkg;

	// widths
	localparam int COORD_BITS  = 16;
	localparam int SIZE_BITS   = COORD_BITS - 1;
	localparam int POS_BITS    = COORD_BITS + 2;
	localparam int SHADOW_BITS = 10;
	localparam int CALC_BITS   = COORD_BITS + 4;
	localparam int CFG_IDX_BITS = 3;

	typedef logic signed [CALC_BITS-1:0] calc_t;
	typedef logic signed [POS_BITS-1:0]  pos_t;

	// saturation limits of the result fields
	localparam calc_t POS_HI = calc_t'((64'sd1 <<< (POS_BITS - 1)) - 64'sd1);
	localparam calc_t POS_LO = ~POS_HI;

	// register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ANCHOR_MODES = 3'd0,
		REG_BOUNDS_MODE  = 3'd1,
		REG_SHIFT_X      = 3'd2,
		REG_SHIFT_Y      = 3'd3,
		REG_AREA_X       = 3'd4,
		REG_AREA_Y       = 3'd5,
		REG_AREA_W       = 3'd6,
		REG_AREA_H       = 3'd7
	} reg_idx_t;

	// anchor codes; the unused code behaves as centre
	localparam logic [1:0] MODE_START  = 2'd0;
	localparam logic [1:0] MODE_CENTRE = 2'd1;
	localparam logic [1:0] MODE_END    = 2'd2;

	// reset values
	localparam logic [7:0]           ANCHOR_RST = 8'd85;
	localparam logic [2:0]           BOUNDS_RST = 3'd7;
	localparam logic [SIZE_BITS-1:0] AREA_W_RST = SIZE_BITS'(1920);
	localparam logic [SIZE_BITS-1:0] AREA_H_RST = SIZE_BITS'(1080);

	// bounds_mode bits
	localparam int BM_PRESENT = 0;
	localparam int BM_FLIP_X  = 1;
	localparam int BM_FLIP_Y  = 2;

	// stage 1: rectangle anchors trimmed by the leading shadow, bounds widened
	typedef struct packed {
		calc_t p_first;
		calc_t p_second;
		calc_t ntrim;
		calc_t win;
		calc_t lo;
		calc_t hi;
	} ax_s1_t;

	// stage 2: primary and flipped candidates
	typedef struct packed {
		calc_t first;
		calc_t second;
		calc_t win;
		calc_t lo;
		calc_t hi;
	} ax_s2_t;

	// stage 3: chosen candidate and clamp limits
	typedef struct packed {
		calc_t val;
		calc_t lo;
		calc_t mx;
		logic  bnd;
		logic  flip;
	} ax_s3_t;

	// stage 4: clamped position and push, not yet saturated
	typedef struct packed {
		calc_t pos;
		calc_t push;
		logic  flip;
	} ax_s4_t;

	// halve truncating toward zero
	function automatic calc_t half(calc_t x);
		calc_t t;
		t = x + calc_t'(x[CALC_BITS-1]);
		return t >>> 1;
	endfunction

	function automatic calc_t point_on(calc_t base, calc_t size, logic [1:0] mode);
		case (mode)
			MODE_START: return base;
			MODE_END:   return base + size;
			default:    return base + half(size);
		endcase
	endfunction

	function automatic logic [1:0] opposite(logic [1:0] mode);
		case (mode)
			MODE_START: return MODE_END;
			MODE_END:   return MODE_START;
			default:    return MODE_CENTRE;
		endcase
	endfunction

	function automatic ax_s1_t ax_stage1(
		logic signed [COORD_BITS-1:0] rbase,
		logic [SIZE_BITS-1:0]         rsize,
		logic [1:0]                   rmode,
		logic [SIZE_BITS-1:0]         win,
		logic [SHADOW_BITS-1:0]       lead,
		logic [SHADOW_BITS-1:0]       trail,
		logic signed [COORD_BITS-1:0] abase,
		logic [SIZE_BITS-1:0]         asize
	);
		ax_s1_t r;
		calc_t  b, s, l, t, w, a;
		b = calc_t'(rbase);
		s = calc_t'(rsize);
		l = calc_t'(lead);
		t = calc_t'(trail);
		w = calc_t'(win);
		a = calc_t'(abase);
		r.p_first  = point_on(b, s, rmode) - l;
		r.p_second = point_on(b, s, opposite(rmode)) - l;
		r.ntrim    = l + t - w;
		r.win      = w;
		r.lo       = a - l;
		r.hi       = a + calc_t'(asize) + t;
		return r;
	endfunction

	function automatic ax_s2_t ax_stage2(
		ax_s1_t                       x,
		logic [1:0]                   wmode,
		logic signed [COORD_BITS-1:0] shift
	);
		ax_s2_t r;
		calc_t  sh;
		sh = calc_t'(shift);
		r.first  = point_on(x.p_first, x.ntrim, wmode) + sh;
		r.second = point_on(x.p_second, x.ntrim, opposite(wmode)) - sh;
		r.win    = x.win;
		r.lo     = x.lo;
		r.hi     = x.hi;
		return r;
	endfunction

	function automatic ax_s3_t ax_stage3(ax_s2_t x, logic bounded, logic may_flip);
		ax_s3_t r;
		logic   over, fits;
		over   = (x.first < x.lo) || (x.first + x.win > x.hi);
		fits   = (x.second >= x.lo) && (x.second + x.win <= x.hi);
		r.flip = bounded && may_flip && over && fits;
		r.val  = r.flip ? x.second : x.first;
		r.lo   = x.lo;
		r.mx   = x.hi - x.win;
		r.bnd  = bounded;
		return r;
	endfunction

	function automatic ax_s4_t ax_stage4(ax_s3_t x);
		ax_s4_t r;
		calc_t  dlo, dmx;
		logic   below, above;
		dlo   = x.lo - x.val;
		dmx   = x.val - x.mx;
		below = x.val < x.lo;
		above = x.val > x.mx;
		r.flip = x.flip;
		r.pos  = x.val;
		r.push = '0;
		if (x.bnd) begin
			// window wider than the area: nearer edge, leading edge on a tie
			if (below && above) begin
				if (dlo <= dmx) begin
					r.pos  = x.lo;
					r.push = dlo;
				end else begin
					r.pos  = x.mx;
					r.push = -dmx;
				end
			end else if (below) begin
				r.pos  = x.lo;
				r.push = dlo;
			end else if (above) begin
				r.pos  = x.mx;
				r.push = -dmx;
			end
		end
		return r;
	endfunction

	function automatic pos_t sat(calc_t v);
		if (v > POS_HI) return pos_t'(POS_HI);
		if (v < POS_LO) return pos_t'(POS_LO);
		return pos_t'(v);
	endfunction

endpackage

@@ sv/popup_anchor_flip_clamp_placer_core.sv @@
// Top level of the popup placer: config registers and a five-stage placement pipeline.
// An accepted transaction passes the valid bits v_s1 to v_s5 in order; done is v_s5.
// Throughput: one transaction per cycle; busy stays low, the pipeline never stalls.
// Stages: rect anchors, window anchors, flip choice, clamp, saturation.
// The receiver cannot hold results off, so nothing back-pressures the stages.
// Reset (arst_n low) clears valid bits and restores the register defaults.
module popup_anchor_flip_clamp_placer_core
	import pafcp_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] rect_x,
	input  logic signed [COORD_BITS-1:0] rect_y,
	input  logic [SIZE_BITS-1:0]         rect_w,
	input  logic [SIZE_BITS-1:0]         rect_h,
	input  logic [SIZE_BITS-1:0]         win_w,
	input  logic [SIZE_BITS-1:0]         win_h,
	input  logic [SHADOW_BITS-1:0]       shadow_top,
	input  logic [SHADOW_BITS-1:0]       shadow_left,
	input  logic [SHADOW_BITS-1:0]       shadow_right,
	input  logic [SHADOW_BITS-1:0]       shadow_bottom,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [COORD_BITS-1:0]        cfg_data,
	output logic                         done,
	output logic signed [POS_BITS-1:0]   pos_x,
	output logic signed [POS_BITS-1:0]   pos_y,
	output logic signed [POS_BITS-1:0]   push_x,
	output logic signed [POS_BITS-1:0]   push_y,
	output logic                         flip_x,
	output logic                         flip_y
);

	logic [7:0]                   anchor_modes_q;
	logic [2:0]                   bounds_mode_q;
	logic signed [COORD_BITS-1:0] shift_x_q, shift_y_q, area_x_q, area_y_q;
	logic [SIZE_BITS-1:0]         area_w_q, area_h_q;

	logic   v_s1, v_s2, v_s3, v_s4, v_s5;
	ax_s1_t ax_s1, ay_s1;
	ax_s2_t ax_s2, ay_s2;
	ax_s3_t ax_s3, ay_s3;
	ax_s4_t ax_s4, ay_s4;
	pos_t   px_s5, py_s5, dx_s5, dy_s5;
	logic   fx_s5, fy_s5;

	logic accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// configuration registers; the user must write them only while no transaction is in flight, not enforced here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_modes_q <= ANCHOR_RST;
			bounds_mode_q  <= BOUNDS_RST;
			shift_x_q      <= '0;
			shift_y_q      <= '0;
			area_x_q       <= '0;
			area_y_q       <= '0;
			area_w_q       <= AREA_W_RST;
			area_h_q       <= AREA_H_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ANCHOR_MODES: anchor_modes_q <= cfg_data[7:0];
				REG_BOUNDS_MODE:  bounds_mode_q  <= cfg_data[2:0];
				REG_SHIFT_X:      shift_x_q      <= cfg_data;
				REG_SHIFT_Y:      shift_y_q      <= cfg_data;
				REG_AREA_X:       area_x_q       <= cfg_data;
				REG_AREA_Y:       area_y_q       <= cfg_data;
				REG_AREA_W:       area_w_q       <= cfg_data[SIZE_BITS-1:0];
				REG_AREA_H:       area_h_q       <= cfg_data[SIZE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: rectangle anchor points, trimmed sizes, widened bounds
	always_ff @(posedge clk) begin
		if (accept) begin
			ax_s1 <= ax_stage1(rect_x, rect_w, anchor_modes_q[1:0], win_w,
				shadow_left, shadow_right, area_x_q, area_w_q);
			ay_s1 <= ax_stage1(rect_y, rect_h, anchor_modes_q[3:2], win_h,
				shadow_top, shadow_bottom, area_y_q, area_h_q);
		end
	end

	// stage 2: window anchor subtracted, shift applied, flipped candidate
	always_ff @(posedge clk) begin
		if (v_s1) begin
			ax_s2 <= ax_stage2(ax_s1, anchor_modes_q[5:4], shift_x_q);
			ay_s2 <= ax_stage2(ay_s1, anchor_modes_q[7:6], shift_y_q);
		end
	end

	// stage 3: with bounds and flip on, keep the flipped candidate only if the first overflows and it fits
	always_ff @(posedge clk) begin
		if (v_s2) begin
			ax_s3 <= ax_stage3(ax_s2, bounds_mode_q[BM_PRESENT], bounds_mode_q[BM_FLIP_X]);
			ay_s3 <= ax_stage3(ay_s2, bounds_mode_q[BM_PRESENT], bounds_mode_q[BM_FLIP_Y]);
		end
	end

	// stage 4: clamp into the widened area when bounds are on
	always_ff @(posedge clk) begin
		if (v_s3) begin
			ax_s4 <= ax_stage4(ax_s3);
			ay_s4 <= ax_stage4(ay_s3);
		end
	end

	// stage 5: saturate to the result range
	always_ff @(posedge clk) begin
		if (v_s4) begin
			px_s5 <= sat(ax_s4.pos);
			py_s5 <= sat(ay_s4.pos);
			dx_s5 <= sat(ax_s4.push);
			dy_s5 <= sat(ay_s4.push);
			fx_s5 <= ax_s4.flip;
			fy_s5 <= ay_s4.flip;
		end
	end

	assign done   = v_s5;
	assign pos_x  = px_s5;
	assign pos_y  = py_s5;
	assign push_x = dx_s5;
	assign push_y = dy_s5;
	assign flip_x = fx_s5;
	assign flip_y = fy_s5;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the popup placer: directed rows, then randomised phases.
module tb_top;
	import pafcp_pkg::*;

	// one placement request as driven on the input ports
	typedef struct {
		logic signed [COORD_BITS-1:0] rx, ry;
		logic [SIZE_BITS-1:0]         rw, rh, ww, wh;
		logic [SHADOW_BITS-1:0]       st, sl, sr, sb;
	} popup_req_t;

	// one placement as seen on the result ports
	typedef struct packed {
		pos_t px, py, dx, dy;
		logic fx, fy;
	} placement_t;

	// register file copy
	typedef struct {
		logic [7:0]                   anchor;
		logic [2:0]                   bounds;
		logic signed [COORD_BITS-1:0] sx, sy, ax, ay;
		logic [SIZE_BITS-1:0]         aw, ah;
	} place_cfg_t;

	typedef struct packed {
		pos_t pos;
		pos_t disp;
		logic flip;
	} axis_out_t;

	typedef struct {
		int         cid;
		popup_req_t req;
		bit         typed;
		placement_t want;
	} dir_row_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start = 1'b0;
	logic                         busy;
	logic signed [COORD_BITS-1:0] rect_x = '0, rect_y = '0;
	logic [SIZE_BITS-1:0]         rect_w = '0, rect_h = '0, win_w = '0, win_h = '0;
	logic [SHADOW_BITS-1:0]       shadow_top = '0, shadow_left = '0;
	logic [SHADOW_BITS-1:0]       shadow_right = '0, shadow_bottom = '0;
	logic                         cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]      cfg_index = '0;
	logic [COORD_BITS-1:0]        cfg_data = '0;
	logic                         done;
	pos_t                         pos_x, pos_y, push_x, push_y;
	logic                         flip_x, flip_y;

	placement_t placements_due[$];
	dir_row_t   dir_rows[$];
	place_cfg_t cur_cfg;
	int         mismatch_count = 0;
	int         burst_left = 0;
	placement_t got_now, want_now;

	popup_anchor_flip_clamp_placer_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.rect_x(rect_x), .rect_y(rect_y), .rect_w(rect_w), .rect_h(rect_h),
		.win_w(win_w), .win_h(win_h),
		.shadow_top(shadow_top), .shadow_left(shadow_left),
		.shadow_right(shadow_right), .shadow_bottom(shadow_bottom),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .pos_x(pos_x), .pos_y(pos_y), .push_x(push_x), .push_y(push_y),
		.flip_x(flip_x), .flip_y(flip_y)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------- predictor ----------------

	// anchor point on one axis; code 3 falls through to centre
	function automatic longint anchor_pt(longint base, longint size, logic [1:0] mode);
		if (mode == MODE_START) return base;
		if (mode == MODE_END) return base + size;
		return base + size / 2;
	endfunction

	function automatic logic [1:0] mirror_mode(logic [1:0] mode);
		if (mode == MODE_START) return MODE_END;
		if (mode == MODE_END) return MODE_START;
		return MODE_CENTRE;
	endfunction

	function automatic pos_t clip_pos(longint v);
		longint top;
		top = (longint'(1) <<< (POS_BITS - 1)) - 1;
		if (v > top) v = top;
		if (v < -top - 1) v = -top - 1;
		return pos_t'(v);
	endfunction

	function automatic axis_out_t solve_axis(longint rbase, longint rsize, logic [1:0] rmode,
			logic [1:0] wmode, longint win, longint lead, longint trail, longint shift,
			logic bounded, logic may_flip, longint abase, longint asize);
		axis_out_t o;
		longint    trimmed, first, second, lo, hi, val, mx, disp;
		logic      flipped;
		trimmed = win - lead - trail;
		first   = anchor_pt(anchor_pt(rbase, rsize, rmode) - lead, -trimmed, wmode) + shift;
		lo      = abase - lead;
		hi      = abase + asize + trail;
		val     = first;
		disp    = 0;
		flipped = 1'b0;
		if (bounded) begin
			// overflow: try the mirrored anchors, keep them only if they fit
			if (may_flip && (first < lo || first + win > hi)) begin
				second = anchor_pt(anchor_pt(rbase, rsize, mirror_mode(rmode)) - lead,
					-trimmed, mirror_mode(wmode)) - shift;
				if (second >= lo && second + win <= hi) begin
					val     = second;
					flipped = 1'b1;
				end
			end
			mx = hi - win;
			// clamp; wider than the area picks the nearer edge, leading on a tie
			if (val < lo && val > mx) begin
				if (lo - val <= val - mx) begin
					disp = lo - val;
					val  = lo;
				end else begin
					disp = mx - val;
					val  = mx;
				end
			end else if (val < lo) begin
				disp = lo - val;
				val  = lo;
			end else if (val > mx) begin
				disp = mx - val;
				val  = mx;
			end
		end
		o.pos  = clip_pos(val);
		o.disp = clip_pos(disp);
		o.flip = flipped;
		return o;
	endfunction

	function automatic placement_t predict_placement(popup_req_t r, place_cfg_t c);
		placement_t p;
		axis_out_t  hx, vy;
		hx = solve_axis(longint'(r.rx), longint'(r.rw), c.anchor[1:0], c.anchor[5:4],
			longint'(r.ww), longint'(r.sl), longint'(r.sr), longint'(c.sx),
			c.bounds[BM_PRESENT], c.bounds[BM_FLIP_X], longint'(c.ax), longint'(c.aw));
		vy = solve_axis(longint'(r.ry), longint'(r.rh), c.anchor[3:2], c.anchor[7:6],
			longint'(r.wh), longint'(r.st), longint'(r.sb), longint'(c.sy),
			c.bounds[BM_PRESENT], c.bounds[BM_FLIP_Y], longint'(c.ay), longint'(c.ah));
		p.px = hx.pos;
		p.py = vy.pos;
		p.dx = hx.disp;
		p.dy = vy.disp;
		p.fx = hx.flip;
		p.fy = vy.flip;
		return p;
	endfunction

	// ---------------- stimulus helpers ----------------

	function automatic logic signed [COORD_BITS-1:0] fit_coord(longint v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return COORD_BITS'(v);
	endfunction

	function automatic logic [SIZE_BITS-1:0] fit_size(longint v);
		if (v > 32767) v = 32767;
		if (v < 0) v = 0;
		return SIZE_BITS'(v);
	endfunction

	function automatic place_cfg_t dir_cfg(int id);
		place_cfg_t c;
		c.anchor = ANCHOR_RST;
		c.bounds = BOUNDS_RST;
		c.sx     = '0;
		c.sy     = '0;
		c.ax     = '0;
		c.ay     = '0;
		c.aw     = AREA_W_RST;
		c.ah     = AREA_H_RST;
		case (id)
			1: begin
				c.anchor = 8'hFF;
				c.bounds = 3'd0;
			end
			2: begin
				c.anchor = 8'h00;
				c.sx = -16'sd32768;
				c.sy = 16'sd32767;
				c.ax = -16'sd32768;
				c.ay = 16'sd32767;
				c.aw = '0;
				c.ah = '1;
			end
			3: begin
				c.anchor = 8'hAA;
				c.bounds = 3'd3;
				c.sx = 16'sd32767;
				c.sy = -16'sd32768;
				c.ax = 16'sd32767;
				c.ay = -16'sd32768;
				c.aw = '1;
				c.ah = '0;
			end
			4: c.anchor = 8'h0A;
			default: ;
		endcase
		return c;
	endfunction

	function automatic place_cfg_t roll_cfg(int phase);
		place_cfg_t c;
		if (phase == 0) begin
			// all registers at their minimum
			c.anchor = 8'h00;
			c.bounds = 3'd0;
			c.sx = -16'sd32768;
			c.sy = -16'sd32768;
			c.ax = -16'sd32768;
			c.ay = -16'sd32768;
			c.aw = '0;
			c.ah = '0;
		end else if (phase == 1) begin
			// all registers at their maximum
			c.anchor = 8'hFF;
			c.bounds = 3'd7;
			c.sx = 16'sd32767;
			c.sy = 16'sd32767;
			c.ax = 16'sd32767;
			c.ay = 16'sd32767;
			c.aw = '1;
			c.ah = '1;
		end else begin
			c.anchor = 8'($urandom);
			c.bounds = ($urandom_range(0, 3) == 0) ? 3'($urandom) : {2'($urandom), 1'b1};
			if ($urandom_range(0, 3) == 0) begin
				c.sx = 16'($urandom);
				c.sy = 16'($urandom);
			end else begin
				c.sx = 16'(int'($urandom_range(0, 80)) - 40);
				c.sy = 16'(int'($urandom_range(0, 80)) - 40);
			end
			if ($urandom_range(0, 3) == 0) begin
				c.ax = 16'($urandom);
				c.ay = 16'($urandom);
				c.aw = 15'($urandom);
				c.ah = 15'($urandom);
			end else begin
				c.ax = 16'(int'($urandom_range(0, 4000)) - 2000);
				c.ay = 16'(int'($urandom_range(0, 4000)) - 2000);
				c.aw = 15'($urandom_range(100, 4000));
				c.ah = 15'($urandom_range(100, 4000));
			end
		end
		return c;
	endfunction

	// mostly requests placed around the work area, the rest raw noise
	function automatic popup_req_t roll_item(place_cfg_t c);
		popup_req_t r;
		int         sh_max;
		longint     span_x, span_y;
		if ($urandom_range(0, 9) < 3) begin
			r.rx = 16'($urandom);
			r.ry = 16'($urandom);
			r.rw = 15'($urandom);
			r.rh = 15'($urandom);
			r.ww = 15'($urandom);
			r.wh = 15'($urandom);
			r.st = 10'($urandom);
			r.sl = 10'($urandom);
			r.sr = 10'($urandom);
			r.sb = 10'($urandom);
		end else begin
			span_x = longint'(c.aw);
			span_y = longint'(c.ah);
			sh_max = ($urandom_range(0, 7) == 0) ? 1023 : 40;
			r.rx = fit_coord(longint'(c.ax) + longint'($urandom_range(0, span_x + 400)) - 200);
			r.ry = fit_coord(longint'(c.ay) + longint'($urandom_range(0, span_y + 400)) - 200);
			r.rw = fit_size($urandom_range(0, 300));
			r.rh = fit_size($urandom_range(0, 300));
			r.ww = fit_size($urandom_range(0, span_x + span_x / 4 + 50));
			r.wh = fit_size($urandom_range(0, span_y + span_y / 4 + 50));
			r.st = 10'($urandom_range(0, sh_max));
			r.sl = 10'($urandom_range(0, sh_max));
			r.sr = 10'($urandom_range(0, sh_max));
			r.sb = 10'($urandom_range(0, sh_max));
		end
		return r;
	endfunction

	function automatic void add_row(int cid, int rx, int ry, int rw, int rh, int ww, int wh,
			int st, int sl, int sr, int sb, bit typed = 1'b0,
			int px = 0, int py = 0, int dx = 0, int dy = 0, bit fx = 1'b0, bit fy = 1'b0);
		dir_row_t d;
		d.cid     = cid;
		d.req.rx  = 16'(rx);
		d.req.ry  = 16'(ry);
		d.req.rw  = 15'(rw);
		d.req.rh  = 15'(rh);
		d.req.ww  = 15'(ww);
		d.req.wh  = 15'(wh);
		d.req.st  = 10'(st);
		d.req.sl  = 10'(sl);
		d.req.sr  = 10'(sr);
		d.req.sb  = 10'(sb);
		d.typed   = typed;
		d.want.px = pos_t'(px);
		d.want.py = pos_t'(py);
		d.want.dx = pos_t'(dx);
		d.want.dy = pos_t'(dy);
		d.want.fx = fx;
		d.want.fy = fy;
		dir_rows.push_back(d);
	endfunction

	// register index and data, one write per edge with the enable held high
	task automatic put_reg(reg_idx_t idx, logic [COORD_BITS-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// narrow registers get random junk above their width
	task automatic apply_config(place_cfg_t c);
		put_reg(REG_ANCHOR_MODES, {8'($urandom), c.anchor});
		put_reg(REG_BOUNDS_MODE, {13'($urandom), c.bounds});
		put_reg(REG_SHIFT_X, c.sx);
		put_reg(REG_SHIFT_Y, c.sy);
		put_reg(REG_AREA_X, c.ax);
		put_reg(REG_AREA_Y, c.ay);
		put_reg(REG_AREA_W, {1'($urandom), c.aw});
		put_reg(REG_AREA_H, {1'($urandom), c.ah});
		cfg_we  <= 1'b0;
		cur_cfg  = c;
	endtask

	// hold off new transactions until every placement has come back
	task automatic drain_placements();
		start <= 1'b0;
		while (placements_due.size() != 0) @(posedge clk);
	endtask

	// one transaction: idle for gap cycles, present the request, wait for acceptance
	task automatic issue_req(popup_req_t r, int gap, bit typed, placement_t want);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		rect_x        <= r.rx;
		rect_y        <= r.ry;
		rect_w        <= r.rw;
		rect_h        <= r.rh;
		win_w         <= r.ww;
		win_h         <= r.wh;
		shadow_top    <= r.st;
		shadow_left   <= r.sl;
		shadow_right  <= r.sr;
		shadow_bottom <= r.sb;
		@(posedge clk);
		while (busy) @(posedge clk);
		placements_due.push_back(typed ? want : predict_placement(r, cur_cfg));
	endtask

	// gap per transaction, with occasional back-to-back bursts
	function automatic int roll_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst_left = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	// ---------------- result checker ----------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			got_now = {pos_x, pos_y, push_x, push_y, flip_x, flip_y};
			if (placements_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected placement: pos=(%0d,%0d) push=(%0d,%0d) flip=%b%b",
						got_now.px, got_now.py, got_now.dx, got_now.dy, got_now.fx, got_now.fy);
			end else begin
				want_now = placements_due.pop_front();
				if (got_now !== want_now) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("placement mismatch: want pos=(%0d,%0d) push=(%0d,%0d) flip=%b%b, %s",
							want_now.px, want_now.py, want_now.dx, want_now.dy,
							want_now.fx, want_now.fy,
							$sformatf("got pos=(%0d,%0d) push=(%0d,%0d) flip=%b%b",
							got_now.px, got_now.py, got_now.dx, got_now.dy,
							got_now.fx, got_now.fy));
				end
			end
		end
	end

	// ---------------- main sequence ----------------
	initial begin
		int cur_id;
		cur_cfg = dir_cfg(0);
		cur_id  = 0;

		// reset defaults: all centre, bounds and both flips on, 1920x1080 area
		add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
		add_row(0, 100, 100, 200, 100, 100, 50, 0, 0, 0, 0, 1, 150, 125, 0, 0);
		// window larger than the area: nearer edge wins
		add_row(0, 0, 0, 0, 0, 32767, 32767, 0, 0, 0, 0, 1, -30847, -31687, -14464, -15304);
		// shadows larger than the window
		add_row(0, 500, 500, 0, 0, 0, 0, 1023, 1023, 1023, 1023, 1, 500, 500, 0, 0);
		// pushed back from the right edge
		add_row(0, 1900, 0, 0, 0, 200, 0, 0, 0, 0, 0, 1, 1720, 0, -80, 0);
		add_row(0, -32768, -32768, 32767, 32767, 32767, 32767, 1023, 1023, 1023, 1023);
		add_row(0, 32767, 32767, 32767, 32767, 32767, 32767, 1023, 0, 1023, 0);
		// unused anchor code, no bounds
		add_row(1, -32768, -32768, 0, 0, 0, 0, 0, 0, 0, 0, 1, -32768, -32768, 0, 0);
		add_row(1, 32767, 32767, 32767, 32767, 0, 0, 0, 0, 0, 0, 1, 49150, 49150, 0, 0);
		add_row(1, 0, 0, 0, 0, 32767, 32767, 0, 0, 0, 0, 1, -16383, -16383, 0, 0);
		add_row(1, 1234, -999, 77, 4321, 600, 300, 1023, 5, 17, 1023);
		// start anchors with extreme shift and area
		add_row(2, -32768, 32767, 0, 32767, 32767, 0, 0, 1023, 0, 1023);
		add_row(2, 32767, -32768, 32767, 0, 0, 32767, 1023, 0, 1023, 0);
		add_row(2, 0, 0, 100, 100, 50, 50, 3, 3, 3, 3);
		// end anchors, horizontal flip only
		add_row(3, 32767, -32768, 32767, 32767, 32767, 32767, 0, 0, 0, 0);
		add_row(3, -32768, 32767, 0, 0, 1, 1, 1023, 1023, 1023, 1023);
		add_row(3, 100, -100, 10, 10, 500, 500, 20, 20, 20, 20);
		// dropdown style anchors: flip taken on both axes, then a flip that does not fit
		add_row(4, 1800, 1000, 100, 50, 300, 100, 0, 0, 0, 0, 1, 1500, 900, 0, 0, 1, 1);
		add_row(4, 1800, 0, 100, 0, 2000, 0, 0, 0, 0, 0, 1, -80, 0, -1980, 0);
		add_row(4, -50, -50, 30, 30, 120, 80, 8, 8, 8, 8);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].cid != cur_id) begin
				drain_placements();
				apply_config(dir_cfg(dir_rows[i].cid));
				cur_id = dir_rows[i].cid;
			end
			issue_req(dir_rows[i].req, $urandom_range(0, 3), dir_rows[i].typed,
				dir_rows[i].want);
		end

		// random phases, each under a fresh register setting
		for (int ph = 0; ph < 14; ph++) begin
			drain_placements();
			apply_config(roll_cfg(ph));
			for (int n = 0; n < 125; n++)
				issue_req(roll_item(cur_cfg), roll_gap(), 1'b0, '0);
		end

		drain_placements();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	// watchdog
	initial begin
		#5000000;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule
